@@ src/sorted_priority_queue_core_defines.svh @@
// Assertion macros for the sorted priority queue core.
// Included by sorted_priority_queue_core.sv, which carries the concurrent assertions; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Generic clocked assertion with an explicit clock and reset
`define SPQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock, masked while reset is high
`define SPQ_ASSERT(label, prop, msg) \
   `SPQ_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue core.
// Used by spq_cell and sorted_priority_queue_core; no dependencies.
package spq_pkg;

   localparam int CAPACITY = 128;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 8;
   localparam int MODE_W   = 2;
   localparam int STAT_W   = 2;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};  // -1

   // Request kinds carried on req_tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_PEEK = 2'd2
   } mode_type;

   // Result status carried on rsp_tuser
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Operation broadcast to every cell in the row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

endpackage

@@ src/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: request decode, fill count, result register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_defines.svh.
`include "sorted_priority_queue_core_defines.svh"

// Bounded min-priority queue of signed 32-bit values, kept sorted in a row of
// CAPACITY cells. req_tuser selects enqueue (0), dequeue (1) or peek (2); mode 3
// is a no-op. Every request gives exactly one result: the smallest value for
// dequeue and peek (-1 with status empty when nothing is stored), 0 for
// enqueue (status full when the value was dropped), plus the occupancy after
// the request. All cells compare against the incoming value in the same cycle
// and shift in one step, so one request is accepted per cycle; the result
// register is the only stage, and a stalled rsp side holds req_tready low
// until the waiting result is taken. Reset needs no clearing pass: the fill
// count alone marks which cells hold data.
module sorted_priority_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [spq_pkg::DATA_W-1:0]        req_tdata,   // [31:0] value
   input  logic [spq_pkg::MODE_W-1:0]        req_tuser,   // [1:0] mode
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [spq_pkg::DATA_W+spq_pkg::OCC_W-1:0] rsp_tdata, // [31:0] result_value,
                                                                // [39:32] occupancy
   output logic [spq_pkg::STAT_W-1:0]        rsp_tuser    // [1:0] status
);
   import spq_pkg::*;

   logic                 accept;
   cell_cmd_type         cmd;
   logic [DATA_W-1:0]    cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_gt;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;

   logic                 is_full;
   logic                 is_empty;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // Row of cells; neighbors hand values up on insert and down on dequeue
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              left_gt;
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_gt   = 1'b0;
         assign left_data = '0;
      end else begin : g_mid
         assign left_gt   = cell_gt[i-1];
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_next
         assign right_data = cell_data[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (CNT_W'(i) < count_ff),
         .left_gt    (left_gt),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .gt         (cell_gt[i])
      );
   end

   // Request decode: cell command, next count and result fields
   always_comb begin
      cmd.op        = CELL_HOLD;
      cmd.value     = req_tdata;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         case (req_tuser)
            MODE_ENQ: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_DEQ: begin
               if (is_empty) begin
                  rsp_value_in  = EMPTY_VALUE;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  cmd.op       = CELL_SHIFT_DOWN;
                  rsp_value_in = cell_data[0];
                  count_in     = count_ff - CNT_W'(1);
               end
            end
            MODE_PEEK: begin
               if (is_empty) begin
                  rsp_value_in  = EMPTY_VALUE;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in = cell_data[0];
               end
            end
            default: begin
               rsp_value_in = '0;
            end
         endcase
         rsp_occ_in = OCC_W'(count_in);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Assertions
   `SPQ_ASSERT(a_count_bound, (count_ff <= CNT_W'(CAPACITY)), "count above capacity")
   `SPQ_ASSERT(a_enq_count, (accept && (req_tuser == MODE_ENQ) && !is_full) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "enqueue did not grow count")
   `SPQ_ASSERT(a_deq_count, (accept && (req_tuser == MODE_DEQ) && !is_empty) |=> (count_ff == $past(count_ff) - CNT_W'(1)), "dequeue did not shrink count")
   `SPQ_ASSERT(a_head_sorted, (count_ff >= CNT_W'(2)) |-> ($signed(cell_data[0]) <= $signed(cell_data[1])), "head cells out of order")

endmodule

@@ src/spq_cell.sv @@
// One slot of the sorted row: holds a value and trades with its neighbors.
// Depends on spq_pkg for the command struct and widths.
module spq_cell (
   input  logic                             clock,
   input  spq_pkg::cell_cmd_type            cmd,
   input  logic                             occupied,
   input  logic                             left_gt,
   input  logic [spq_pkg::DATA_W-1:0]       left_data,
   input  logic [spq_pkg::DATA_W-1:0]       right_data,
   output logic [spq_pkg::DATA_W-1:0]       data,
   output logic                             gt
);
   import spq_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // An empty slot counts as larger than any value
   assign gt   = !occupied || ($signed(data_ff) > $signed(cmd.value));
   assign data = data_ff;

   // Insert: larger slots move up one; the first larger slot takes the new value
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (gt) begin
               data_in = left_gt ? left_data : cmd.value;
            end
         end
         CELL_SHIFT_DOWN: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
